[rtl/inb_pkg.sv]
// Package for the impulse noise blanker: widths, defaults, register indices
// and the configuration struct. No dependencies.
package inb_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int DELAY_DEPTH_DEF  = 8;
    localparam int DELAY_OFFSET_DEF = 2;
    localparam int HANG_SAMPLES_DEF = 7;

    localparam int THR_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RAD_W    = 34;
    localparam int MAG_W    = 17;
    localparam int AVGM_W   = 40;
    localparam int FRAC_SH  = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd845;
    localparam logic [AVGM_W-1:0] AVGM_RST      = 40'd65536;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic             blank_mode;
    } t_cfg;
endpackage

[rtl/inb_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module inb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/inb_queue.sv]
// Short FIFO between the front and back parts of the blanker.
// No dependencies.
module inb_queue #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= f_inc(r_wp);
            if (i_pop)  r_rp <= f_inc(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
endmodule

[rtl/inb_front.sv]
// Front part: accepts a sample, forms i^2+q^2 on one shared multiplier and
// pushes sample and scaled radicand into the queue. Uses inb_pkg.
module inb_front #(
    parameter int SAMPLE_WIDTH = inb_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    output logic                           o_push,
    output logic [2*SAMPLE_WIDTH+inb_pkg::RAD_W-1:0] o_push_data,
    input  logic                           i_full
);
    import inb_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int SH  = RAD_W - 2 * SW;
    localparam int SHL = (SH > 0) ? SH : 0;
    localparam int SHR = (SH < 0) ? -SH : 0;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQI  = 2'd1;
    localparam logic [1:0] F_SQQ  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]             r_state, n_state;
    logic signed [SW-1:0]   r_xi, r_xq;
    logic [2*SW-1:0]        r_sum;
    logic signed [SW-1:0]   op;
    logic signed [2*SW-1:0] sq;
    logic [63:0]            wide;
    logic [RAD_W-1:0]       rad;

    assign op   = (r_state == F_SQI) ? r_xi : r_xq;
    assign sq   = op * op;
    assign wide = 64'(r_sum);
    assign rad  = RAD_W'((wide << SHL) >> SHR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_in_valid) n_state = F_SQI;
            F_SQI:  n_state = F_SQQ;
            F_SQQ:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_xi <= i_sample_i;
            r_xq <= i_sample_q;
        end
        if (r_state == F_SQI) r_sum <= (2*SW)'(sq);
        if (r_state == F_SQQ) r_sum <= r_sum + (2*SW)'(sq);
    end

    assign o_in_stall  = (r_state != F_IDLE);
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_push_data = {r_xq, r_xi, rad};
endmodule

[rtl/inb_back.sv]
// Back part: iterative square root, magnitude average, detection and the two
// blanking modes, with an output register. Uses inb_pkg and inb_ram.
module inb_back #(
    parameter int SAMPLE_WIDTH = inb_pkg::SAMPLE_WIDTH_DEF,
    parameter int DELAY_DEPTH  = inb_pkg::DELAY_DEPTH_DEF,
    parameter int DELAY_OFFSET = inb_pkg::DELAY_OFFSET_DEF,
    parameter int HANG_SAMPLES = inb_pkg::HANG_SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  inb_pkg::t_cfg                  i_cfg,
    input  logic                           i_empty,
    input  logic [2*SAMPLE_WIDTH+inb_pkg::RAD_W-1:0] i_data,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_q,
    output logic                           o_was_blanked
);
    import inb_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = SW + 8;
    localparam int DW   = $clog2(DELAY_DEPTH);
    localparam int HW   = $clog2(HANG_SAMPLES + 1);
    localparam int OFFM = DELAY_OFFSET % DELAY_DEPTH;
    localparam int SCW  = $clog2(MAG_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQRT = 3'd1;
    localparam logic [2:0] S_AVG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic signed [SW-1:0]    r_xi, r_xq;
    logic [RAD_W-1:0]        r_rad;
    logic [MAG_W+2:0]        r_rem;
    logic [MAG_W-1:0]        r_root;
    logic [SCW-1:0]          r_cnt;
    logic [AVGM_W-1:0]       r_avgm;
    logic [AVGM_W+THR_W-1:0] r_prod;
    logic signed [AW-1:0]    r_avg_i, r_avg_q;
    logic [DW-1:0]           r_wi;
    logic [HW-1:0]           r_hang;
    logic [DELAY_DEPTH-1:0]  r_valid;
    logic                    r_rd_vld;
    logic                    r_out_vld;
    logic signed [SW-1:0]    r_out_i, r_out_q;
    logic                    r_out_blk;

    // square root step
    logic [MAG_W+4:0] rem2;
    logic [MAG_W+4:0] trial;
    assign rem2  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial = (MAG_W+5)'({r_root, 2'b01});

    // magnitude average update
    logic signed [AVGM_W+1:0]         diff;
    logic signed [AVGM_W+FRAC_SH+1:0] acc;
    logic [AVGM_W-1:0]                avgm_new;
    assign diff = $signed({2'b00, (AVGM_W)'(r_root)}) - $signed({2'b00, r_avgm});
    assign acc  = $signed({2'b00, r_avgm, FRAC_SH'(0)})
                + (AVGM_W+FRAC_SH+2)'(diff <<< 10) + (AVGM_W+FRAC_SH+2)'(diff <<< 4)
                + (AVGM_W+FRAC_SH+2)'(diff <<< 3) + (AVGM_W+FRAC_SH+2)'(diff);
    assign avgm_new = AVGM_W'(acc >>> FRAC_SH);

    logic hit;
    assign hit = (AVGM_W+THR_W)'({r_root, 8'd0}) > r_prod;

    // ring indices
    logic [DW:0]   rsum;
    logic [DW-1:0] ri;
    logic [DW-1:0] wi_next;
    assign rsum    = (DW+1)'(r_wi) + (DW+1)'(OFFM);
    assign ri      = (rsum >= (DW+1)'(DELAY_DEPTH)) ? DW'(rsum - (DW+1)'(DELAY_DEPTH))
                                                    : DW'(rsum);
    assign wi_next = (r_wi == '0) ? DW'(DELAY_DEPTH - 1) : r_wi - 1'b1;

    logic [2*SW-1:0] rd_data;
    logic            out_free, fire, ram_we, pop;
    assign out_free = !r_out_vld || !i_out_stall;
    assign pop      = (r_state == S_IDLE) && !i_empty;
    assign fire     = (r_state == S_DONE) && out_free;
    assign ram_we   = fire && !i_cfg.blank_mode;

    inb_ram #(.WIDTH(2*SW), .DEPTH(DELAY_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wi),
        .i_wdata ({r_xq, r_xi}),
        .i_re    (pop),
        .i_raddr (ri),
        .o_rdata (rd_data)
    );

    // complex average
    logic signed [AW+2:0] nai, naq;
    logic signed [AW-1:0] avg_i_new, avg_q_new;
    logic signed [SW-1:0] rep_i, rep_q;

    function automatic logic signed [SW-1:0] f_round(input logic signed [AW-1:0] a);
        logic signed [AW:0]   t;
        logic signed [SW:0]   o;
        t = (AW+1)'(a) + (AW+1)'(128);
        o = (SW+1)'(t >>> 8);
        if (o > (SW+1)'(2**(SW-1) - 1))       f_round = {1'b0, {(SW-1){1'b1}}};
        else if (o < -(SW+1)'(2**(SW-1)))     f_round = {1'b1, {(SW-1){1'b0}}};
        else                                  f_round = SW'(o);
    endfunction

    assign nai = ((AW+3)'(r_avg_i) * (AW+3)'(3) + ((AW+3)'(r_xi) <<< 8)) >>> 2;
    assign naq = ((AW+3)'(r_avg_q) * (AW+3)'(3) + ((AW+3)'(r_xq) <<< 8)) >>> 2;
    assign avg_i_new = AW'(nai);
    assign avg_q_new = AW'(naq);
    assign rep_i = f_round(avg_i_new);
    assign rep_q = f_round(avg_q_new);

    // delayed sample, with bypass when read and write land on one entry
    logic signed [SW-1:0] dl_i, dl_q;
    logic [HW-1:0]        hc;
    always_comb begin
        if (ri == r_wi) begin
            dl_i = r_xi;
            dl_q = r_xq;
        end else if (r_rd_vld) begin
            dl_i = rd_data[SW-1:0];
            dl_q = rd_data[2*SW-1:SW];
        end else begin
            dl_i = '0;
            dl_q = '0;
        end
        hc = (r_hang == '0 && hit) ? HW'(HANG_SAMPLES) : r_hang;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_SQRT;
            S_SQRT: if (r_cnt == SCW'(MAG_W - 1)) n_state = S_AVG;
            S_AVG:  n_state = S_MUL;
            S_MUL:  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_avgm    <= AVGM_RST;
            r_avg_i   <= '0;
            r_avg_q   <= '0;
            r_wi      <= '0;
            r_hang    <= '0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_AVG) r_avgm <= avgm_new;
            if (fire) begin
                r_out_vld <= 1'b1;
                if (!i_cfg.blank_mode) begin
                    r_valid[r_wi] <= 1'b1;
                    r_wi          <= wi_next;
                    r_hang        <= (hc != '0) ? hc - 1'b1 : hc;
                end else begin
                    r_avg_i <= avg_i_new;
                    r_avg_q <= avg_q_new;
                end
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_xi     <= i_data[RAD_W +: SW];
            r_xq     <= i_data[RAD_W+SW +: SW];
            r_rad    <= i_data[RAD_W-1:0];
            r_rem    <= '0;
            r_root   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= r_valid[ri];
        end
        if (r_state == S_SQRT) begin
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt + 1'b1;
            if (rem2 >= trial) begin
                r_rem  <= (MAG_W+3)'(rem2 - trial);
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= (MAG_W+3)'(rem2);
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
        if (r_state == S_MUL) r_prod <= i_cfg.threshold * r_avgm;
        if (fire) begin
            if (!i_cfg.blank_mode) begin
                r_out_blk <= (hc != '0);
                r_out_i   <= (hc != '0) ? '0 : dl_i;
                r_out_q   <= (hc != '0) ? '0 : dl_q;
            end else begin
                r_out_blk <= hit;
                r_out_i   <= hit ? rep_i : r_xi;
                r_out_q   <= hit ? rep_q : r_xq;
            end
        end
    end

    assign o_pop         = pop;
    assign o_out_valid   = r_out_vld;
    assign o_out_i       = r_out_i;
    assign o_out_q       = r_out_q;
    assign o_was_blanked = r_out_blk;
endmodule

[rtl/impulse_noise_blanker.sv]
// Impulse noise blanker top level: configuration registers, front, queue, back.
// Path from accepted sample to result valid: front (square I, square Q, push),
// queue pop, the iterative square root, average, multiply, result register.
// The front stalls input until it has pushed its sample; the rate is set by the back.
// Reset (synchronous, active low) restores threshold 845, mode 0, average
// magnitude 1.0, cleared averages, ring marked empty (reads as zero), hang 0.
module impulse_noise_blanker #(
    parameter int SAMPLE_WIDTH = inb_pkg::SAMPLE_WIDTH_DEF,
    parameter int DELAY_DEPTH  = inb_pkg::DELAY_DEPTH_DEF,
    parameter int DELAY_OFFSET = inb_pkg::DELAY_OFFSET_DEF,
    parameter int HANG_SAMPLES = inb_pkg::HANG_SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [inb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [inb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_q,
    output logic                           o_was_blanked
);
    import inb_pkg::*;

    localparam int QW = 2 * SAMPLE_WIDTH + RAD_W;

    t_cfg r_cfg;

    // hold configuration; ignore indices beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= THRESHOLD_RST;
            r_cfg.blank_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_cfg.threshold  <= i_cfg_data[THR_W-1:0];
                CFG_MODE:      r_cfg.blank_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic          push, full, pop, empty;
    logic [QW-1:0] push_data, pop_data;

    // front: accept and square
    inb_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // decouple the two parts
    inb_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (empty)
    );

    // back: root, average, detect, blank
    inb_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DELAY_DEPTH  (DELAY_DEPTH),
        .DELAY_OFFSET (DELAY_OFFSET),
        .HANG_SAMPLES (HANG_SAMPLES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_data        (pop_data),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_i       (o_out_i),
        .o_out_q       (o_out_q),
        .o_was_blanked (o_was_blanked)
    );
endmodule
